@@ rtl/pts_pkg.sv @@
// Shared types and constants of the periodic timestamp tagger.
package pts_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_SYNC  = 2'd1,
		MODE_RATE  = 2'd2,
		MODE_SPARE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_STAMP_PERIOD = 2'd0,
		CFG_FRAC_STEP    = 2'd1,
		CFG_SAMPLE_RATE  = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	localparam int unsigned SECS_W  = 32;
	localparam int unsigned FRAC_W  = 32;
	localparam int unsigned INDEX_W = 48;
	localparam int unsigned SLOT_W  = 32;
	localparam int unsigned RATE_W  = 30;
	localparam int unsigned CFG_W   = 32;

	localparam logic [31:0]     STAMP_PERIOD_RST = 32'd1000;
	localparam logic [31:0]     FRAC_STEP_RST    = 32'd0;
	localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 30'd1000000;

	// Classified sample word passed from the front to the back.
	typedef struct packed {
		logic              sync;
		logic [SECS_W-1:0] secs;
		logic [FRAC_W-1:0] frac;
		logic              rate_err;
	} item_t;

	// Live configuration seen by the back.
	typedef struct packed {
		logic [31:0]       stamp_period;
		logic [FRAC_W-1:0] frac_step;
	} back_cfg_t;

endpackage

@@ rtl/pts_front.sv @@
// Front: decodes the sample mode and checks rate announcements.
module pts_front (
	input  logic [1:0]                 mode,
	input  logic [pts_pkg::SECS_W-1:0] sync_secs,
	input  logic [pts_pkg::FRAC_W-1:0] sync_frac,
	input  logic [pts_pkg::RATE_W-1:0] announced_rate,
	input  logic [pts_pkg::RATE_W-1:0] sample_rate_hz,
	output pts_pkg::item_t             item
);

	pts_pkg::mode_t mode_dec;

	always_comb begin
		mode_dec      = pts_pkg::mode_t'(mode);
		item.sync     = 1'b0;
		item.rate_err = 1'b0;
		item.secs     = sync_secs;
		item.frac     = sync_frac;
		case (mode_dec)
			pts_pkg::MODE_SYNC: begin
				item.sync = 1'b1;
			end
			pts_pkg::MODE_RATE: begin
				item.rate_err = (announced_rate != sample_rate_hz);
			end
			default: begin
				// plain sample, spare code included
				item.sync = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/pts_queue.sv @@
// Small FIFO of classified sample words between front and back.
module pts_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pts_pkg::item_t push_item,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output pts_pkg::item_t pop_item
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pts_pkg::item_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = (count_q != FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/pts_back.sv @@
// Back: sample counter, time keeping and the registered result word.
module pts_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pts_pkg::back_cfg_t          cfg,
	input  logic                        item_valid,
	input  pts_pkg::item_t              item,
	output logic                        item_pop,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        stamp_valid,
	output logic [pts_pkg::SECS_W-1:0]  stamp_secs,
	output logic [pts_pkg::FRAC_W-1:0]  stamp_frac,
	output logic [pts_pkg::INDEX_W-1:0] stamp_index,
	output logic [pts_pkg::SLOT_W-1:0]  slot_number,
	output logic                        rate_error
);

	logic [pts_pkg::INDEX_W-1:0] sample_count_q;
	logic [pts_pkg::INDEX_W-1:0] next_index_q;
	logic [pts_pkg::SECS_W-1:0]  secs_q;
	logic [pts_pkg::FRAC_W-1:0]  frac_q;
	logic [pts_pkg::SLOT_W-1:0]  slot_q;
	logic                        out_valid_q;

	logic                        emit;
	logic [pts_pkg::INDEX_W-1:0] base_index;
	logic [pts_pkg::FRAC_W:0]    frac_sum;
	logic [pts_pkg::SECS_W-1:0]  secs_now;
	logic [pts_pkg::FRAC_W-1:0]  frac_now;
	logic [31:0]                 interval;

	assign item_pop     = item_valid && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;

	always_comb begin
		emit       = item.sync || (sample_count_q == next_index_q);
		base_index = item.sync ? sample_count_q : next_index_q;
		frac_sum   = {1'b0, frac_q} + {1'b0, cfg.frac_step};
		interval   = (cfg.stamp_period == '0) ? 32'd1 : cfg.stamp_period;
		if (item.sync) begin
			// sync loads the time and stamps this sample without advance
			secs_now = item.secs;
			frac_now = item.frac;
		end else begin
			secs_now = secs_q + {31'd0, frac_sum[pts_pkg::FRAC_W]};
			frac_now = frac_sum[pts_pkg::FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			next_index_q   <= {16'd0, pts_pkg::STAMP_PERIOD_RST};
			secs_q         <= '0;
			frac_q         <= '0;
			slot_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (item_pop) begin
				sample_count_q <= sample_count_q + 1'b1;
				if (emit) begin
					secs_q       <= secs_now;
					frac_q       <= frac_now;
					slot_q       <= slot_q + 1'b1;
					next_index_q <= base_index + {16'd0, interval};
				end
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word; stamp fields read zero when no stamp falls on the sample
	always_ff @(posedge clk) begin
		if (item_pop) begin
			stamp_valid <= emit;
			stamp_secs  <= emit ? secs_now : '0;
			stamp_frac  <= emit ? frac_now : '0;
			stamp_index <= emit ? base_index : '0;
			slot_number <= emit ? slot_q : '0;
			rate_error  <= item.rate_err;
		end
	end

endmodule

@@ rtl/periodic_timestamp_tagger.sv @@
// Top level: configuration registers, front decode, word queue and back.
// A sample word goes through a queue entry and then the back's result register.
// Throughput: one sample per cycle while results are taken, set by the counter
// and time update in the back; the queue absorbs a stalled result port.
// Reset (arst_n low): registers return to defaults, counters clear, next stamp
// index returns to the default interval, queue and result register empty.
module periodic_timestamp_tagger #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [pts_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [1:0]                  mode,
	input  logic [pts_pkg::SECS_W-1:0]  sync_secs,
	input  logic [pts_pkg::FRAC_W-1:0]  sync_frac,
	input  logic [pts_pkg::RATE_W-1:0]  announced_rate,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        stamp_valid,
	output logic [pts_pkg::SECS_W-1:0]  stamp_secs,
	output logic [pts_pkg::FRAC_W-1:0]  stamp_frac,
	output logic [pts_pkg::INDEX_W-1:0] stamp_index,
	output logic [pts_pkg::SLOT_W-1:0]  slot_number,
	output logic                        rate_error
);

	logic [31:0]                stamp_period_q;
	logic [pts_pkg::FRAC_W-1:0] frac_step_q;
	logic [pts_pkg::RATE_W-1:0] sample_rate_q;

	pts_pkg::item_t     front_item;
	pts_pkg::item_t     queue_item;
	pts_pkg::back_cfg_t back_cfg;
	logic               queue_not_empty;
	logic               queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_period_q <= pts_pkg::STAMP_PERIOD_RST;
			frac_step_q    <= pts_pkg::FRAC_STEP_RST;
			sample_rate_q  <= pts_pkg::SAMPLE_RATE_RST;
		end else if (cfg_we) begin
			case (pts_pkg::cfg_idx_t'(cfg_index))
				pts_pkg::CFG_STAMP_PERIOD: stamp_period_q <= cfg_data;
				pts_pkg::CFG_FRAC_STEP:    frac_step_q    <= cfg_data;
				pts_pkg::CFG_SAMPLE_RATE:  sample_rate_q  <= cfg_data[pts_pkg::RATE_W-1:0];
				default:                   stamp_period_q <= stamp_period_q;
			endcase
		end
	end

	assign back_cfg.stamp_period = stamp_period_q;
	assign back_cfg.frac_step    = frac_step_q;

	pts_front u_front (
		.mode           (mode),
		.sync_secs      (sync_secs),
		.sync_frac      (sync_frac),
		.announced_rate (announced_rate),
		.sample_rate_hz (sample_rate_q),
		.item           (front_item)
	);

	pts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (sample_valid),
		.push_item (front_item),
		.not_full  (sample_ready),
		.pop       (queue_pop),
		.not_empty (queue_not_empty),
		.pop_item  (queue_item)
	);

	pts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (back_cfg),
		.item_valid   (queue_not_empty),
		.item         (queue_item),
		.item_pop     (queue_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stamp_valid  (stamp_valid),
		.stamp_secs   (stamp_secs),
		.stamp_frac   (stamp_frac),
		.stamp_index  (stamp_index),
		.slot_number  (slot_number),
		.rate_error   (rate_error)
	);

endmodule
